@@ rtl/hdsp_pkg.sv @@
// ----------------------------------------------------------------------------
// hdsp_pkg
// Shared constants, month name table and scan summary type for the HTTP date
// string parser.
// ----------------------------------------------------------------------------
package hdsp_pkg;

  localparam int MAX_CHARS = 200;
  localparam int CNT_W     = $clog2(MAX_CHARS + 2);
  localparam int NUM_SLOTS = 5;
  localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
  localparam int FOUND_W   = $clog2(NUM_SLOTS + 1);
  localparam int NUM_W     = 16;
  localparam int YEAR_W    = 17;

  localparam logic [3:0] MONTH_NONE  = 4'd15;
  localparam logic [3:0] MONTH_COUNT = 4'd12;

  localparam logic [NUM_W-1:0]  NUM_MAX      = 16'hFFFF;
  localparam logic [NUM_W-1:0]  FULL_YEAR    = 16'd1000;
  localparam logic [NUM_W-1:0]  YEAR_PIVOT   = 16'd50;
  localparam logic [YEAR_W-1:0] YEAR_BASE    = 17'd1900;
  localparam logic [YEAR_W-1:0] CENTURY      = 17'd100;

  localparam logic [7:0] MONTH_NAMES [36] = '{
    "j", "a", "n",  "f", "e", "b",  "m", "a", "r",  "a", "p", "r",
    "m", "a", "y",  "j", "u", "n",  "j", "u", "l",  "a", "u", "g",
    "s", "e", "p",  "o", "c", "t",  "n", "o", "v",  "d", "e", "c"
  };

  typedef struct packed {
    logic                        ok;
    logic [3:0]                  month;
    logic [NUM_SLOTS-1:0][NUM_W-1:0] slots;
  } scan_t;

endpackage

@@ rtl/http_date_string_parser_top.sv @@
// ----------------------------------------------------------------------------
// http_date_string_parser_top
// Parses an RFC 822 / RFC 850 / asctime style date string, one character per
// transfer, and returns the broken-down date after the last character.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid, in_stall | char_code, last_char
//   out     | output    | out_valid, out_stall | valid_res, year, month,
//           |           |                    | day_of_month, hour, minute, second
//
// One character per cycle while in_stall is low; the tokenizer state
// updates in the cycle of the transfer and the result register loads on
// the last character; the result appears in the cycle after it is taken.
// in_stall is high only while a result is held and out_stall is high.
// Synchronous reset clears the tokenizer state and the result valid.
// ----------------------------------------------------------------------------
module http_date_string_parser_top
  import hdsp_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               char_code,
  input  logic                     last_char,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     valid_res,
  output logic signed [YEAR_W-1:0] year,
  output logic [3:0]               month,
  output logic [NUM_W-1:0]         day_of_month,
  output logic [NUM_W-1:0]         hour,
  output logic [NUM_W-1:0]         minute,
  output logic [NUM_W-1:0]         second
);

  logic             accept;
  scan_t            summary;
  logic [NUM_W-1:0] n1, n2, n3, n4;
  logic [YEAR_W-1:0] year_calc;
  logic [NUM_W-1:0] hour_calc, minute_calc, second_calc;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  hdsp_scan u_scan (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .char_code (char_code),
    .last_char (last_char),
    .summary   (summary)
  );

  always_comb begin
    n1 = summary.slots[1];
    n2 = summary.slots[2];
    n3 = summary.slots[3];
    n4 = summary.slots[4];
    if (n4 >= FULL_YEAR) begin
      year_calc   = {1'b0, n4} - YEAR_BASE;
      hour_calc   = n1;
      minute_calc = n2;
      second_calc = n3;
    end else begin
      hour_calc   = n2;
      minute_calc = n3;
      second_calc = n4;
      priority if (n1 <= YEAR_PIVOT) begin
        year_calc = {1'b0, n1} + CENTURY;
      end else if (n1 < FULL_YEAR) begin
        year_calc = {1'b0, n1};
      end else begin
        year_calc = {1'b0, n1} - YEAR_BASE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && last_char) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_char) begin
      valid_res <= summary.ok;
      if (summary.ok) begin
        year         <= $signed(year_calc);
        month        <= summary.month;
        day_of_month <= summary.slots[0];
        hour         <= hour_calc;
        minute       <= minute_calc;
        second       <= second_calc;
      end else begin
        year         <= '0;
        month        <= '0;
        day_of_month <= '0;
        hour         <= '0;
        minute       <= '0;
        second       <= '0;
      end
    end
  end

endmodule

@@ rtl/hdsp_scan.sv @@
// ----------------------------------------------------------------------------
// hdsp_scan
// Per-character tokenizer: month token match, number accumulate and slot fill.
// Presents the end-of-string summary for the character being accepted.
// ----------------------------------------------------------------------------
module hdsp_scan
  import hdsp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] char_code,
  input  logic       last_char,
  output scan_t      summary
);

  typedef enum logic [1:0] {
    PH_LEAD,
    PH_SIGN,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  function automatic logic [3:0] month_hit(input logic [2:0][7:0] pre,
                                           input logic [2:0] len);
    logic [3:0] hit;
    logic       same;
    hit = MONTH_NONE;
    for (int m = 11; m >= 0; m--) begin
      for (int off = 0; off < 3; off++) begin
        if (off + int'(len) <= 3) begin
          same = 1'b1;
          for (int k = 0; k < 3; k++) begin
            if (k < int'(len)) begin
              if (MONTH_NAMES[m*3 + off + k] != pre[k]) begin
                same = 1'b0;
              end
            end
          end
          if (same) begin
            hit = 4'(m);
          end
        end
      end
    end
    return hit;
  endfunction

  logic [CNT_W-1:0]                count, count_next;
  logic [2:0][7:0]                 pre, pre_next;
  logic [2:0]                      len, len_next;
  phase_t                          phase, phase_next;
  logic [NUM_W-1:0]                value, value_next;
  logic [3:0]                      month, month_next;
  logic [NUM_SLOTS-1:0][NUM_W-1:0] slots, slots_next;
  logic [FOUND_W-1:0]              found, found_next;

  logic [7:0]       c;
  logic             sep, digit, ws, close;
  logic [3:0]       dval;
  logic [19:0]      mac;
  logic [2:0][7:0]  a_pre;
  logic [2:0]       a_len;
  phase_t           a_phase;
  logic [NUM_W-1:0] a_value;
  logic             a_store, b_store;
  logic [3:0]       hit;

  always_comb begin
    c = char_code;
    if (char_code >= "A" && char_code <= "Z") begin
      c = char_code + 8'd32;
    end
    sep   = (c == " ") || (c == "-") || (c == ":") || (c == ",");
    digit = (c >= "0") && (c <= "9");
    ws    = (c >= 8'd9) && (c <= 8'd13);
    dval  = 4'(c - "0");
    mac   = ({4'b0, value} << 3) + ({4'b0, value} << 1) + {16'b0, dval};

    a_pre   = pre;
    a_len   = len;
    a_phase = phase;
    a_value = value;
    a_store = 1'b0;
    if (!sep) begin
      if (len < 3'd3) begin
        a_pre[len[1:0]] = c;
      end
      if (len < 3'd4) begin
        a_len = len + 3'd1;
      end
      unique case (phase)
        PH_LEAD: begin
          if (!ws) begin
            if (c == "+") begin
              a_phase = PH_SIGN;
            end else if (digit) begin
              a_value = {12'b0, dval};
              a_phase = PH_DIGITS;
            end else begin
              a_phase = PH_DONE;
            end
          end
        end
        PH_SIGN: begin
          if (digit) begin
            a_value = {12'b0, dval};
            a_phase = PH_DIGITS;
          end else begin
            a_phase = PH_DONE;
          end
        end
        PH_DIGITS: begin
          if (digit) begin
            a_value = (mac > {4'b0, NUM_MAX}) ? NUM_MAX : mac[NUM_W-1:0];
          end else begin
            a_store = 1'b1;
            a_phase = PH_DONE;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase
    end

    close      = sep || last_char;
    hit        = month_hit(a_pre, a_len);
    b_store    = a_store;
    month_next = month;
    if (close && a_len != 3'd0) begin
      if (a_len <= 3'd3 && hit != MONTH_NONE) begin
        month_next = hit;
      end else if (a_phase == PH_DIGITS) begin
        b_store = 1'b1;
      end
    end

    slots_next = slots;
    found_next = found;
    if (b_store && found < FOUND_W'(NUM_SLOTS)) begin
      slots_next[found[SLOT_IDX_W-1:0]] = a_value;
      found_next = found + 1'b1;
    end

    if (close) begin
      pre_next   = '0;
      len_next   = '0;
      phase_next = PH_LEAD;
      value_next = '0;
    end else begin
      pre_next   = a_pre;
      len_next   = a_len;
      phase_next = a_phase;
      value_next = a_value;
    end

    count_next = (count <= CNT_W'(MAX_CHARS)) ? count + 1'b1 : count;

    summary.ok    = (count_next <= CNT_W'(MAX_CHARS)) && (month_next < MONTH_COUNT) &&
                    (found_next >= FOUND_W'(NUM_SLOTS));
    summary.month = month_next;
    summary.slots = slots_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last_char)) begin
      count <= '0;
      pre   <= '0;
      len   <= '0;
      phase <= PH_LEAD;
      value <= '0;
      month <= MONTH_NONE;
      found <= '0;
    end else if (accept) begin
      count <= count_next;
      pre   <= pre_next;
      len   <= len_next;
      phase <= phase_next;
      value <= value_next;
      month <= month_next;
      found <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slots <= slots_next;
    end
  end

endmodule
